@@ hdl/prfv_pkg.sv @@
package prfv_pkg;

	// Frame limits
	localparam int unsigned MAX_FRAME_BYTES = 256;
	localparam int unsigned MIN_FRAME_LEN   = 7;
	localparam int unsigned FIRST_SIZE_POS  = 4;
	localparam int unsigned ID_BYTES        = 2;

	// Byte position saturates at MAX_FRAME_BYTES
	localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
	// Next size position reaches at most (MAX_FRAME_BYTES - 1) + 255 + ID_BYTES + 1
	localparam int unsigned NSP_W = $clog2(MAX_FRAME_BYTES + 255 + ID_BYTES + 1);

	localparam int unsigned IDX_W   = 7;
	localparam int unsigned OFF_W   = 9;
	localparam logic [IDX_W-1:0] ITEMS_SAT = {IDX_W{1'b1}};

	typedef enum logic {
		KIND_HEADER  = 1'b0,
		KIND_VERDICT = 1'b1
	} result_kind_t;

	typedef struct packed {
		result_kind_t     kind;
		logic [IDX_W-1:0] item_index;
		logic [15:0]      param_id;
		logic [7:0]       item_size;
		logic [OFF_W-1:0] data_offset;
		logic             frame_valid;
		logic [IDX_W-1:0] item_count;
	} result_t;

endpackage

@@ hdl/prfv_input_stage.sv @@
module prfv_input_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       last_s1
);

	// Take a new item when the slot is empty or its item moves on this cycle
	assign in_ready = !valid_s1 || advance;

	// Hold the occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

endmodule

@@ hdl/prfv_frame_tracker.sv @@
module prfv_frame_tracker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [15:0]       cfg_wr_data,
	input  logic              advance,
	input  logic [7:0]        byte_s1,
	input  logic              last_s1,
	output logic              res_valid,
	output prfv_pkg::result_t res
);

	logic [15:0]                expected_type_q;
	logic [prfv_pkg::POS_W-1:0] pos_q;
	logic [prfv_pkg::NSP_W-1:0] nsp_q;
	logic [prfv_pkg::IDX_W-1:0] items_q;
	logic [15:0]                last2_q;
	logic [7:0]                 type_lo_q;
	logic                       type_ok_q;
	logic                       too_long_q;

	logic                       hdr;
	logic                       type_ok_n;
	logic [7:0]                 type_lo_n;
	logic [15:0]                last2_n;
	logic [prfv_pkg::IDX_W-1:0] items_n;
	logic [prfv_pkg::NSP_W-1:0] nsp_n;
	logic [prfv_pkg::NSP_W-1:0] len;
	logic                       ok;
	logic                       at_limit;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_type_q <= '0;
		end else if (cfg_wr_en) begin
			expected_type_q <= cfg_wr_data;
		end
	end

	// Per-byte update of the frame state
	always_comb begin
		hdr       = !too_long_q && (prfv_pkg::NSP_W'(pos_q) == nsp_q);
		type_lo_n = (pos_q == '0) ? byte_s1 : type_lo_q;
		type_ok_n = type_ok_q;
		if (pos_q == prfv_pkg::POS_W'(1)) begin
			type_ok_n = ({byte_s1, type_lo_q} == expected_type_q);
		end
		last2_n = {last2_q[7:0], byte_s1};
		items_n = items_q;
		nsp_n   = nsp_q;
		if (hdr) begin
			if (items_q != prfv_pkg::ITEMS_SAT) begin
				items_n = items_q + prfv_pkg::IDX_W'(1);
			end
			nsp_n = prfv_pkg::NSP_W'(pos_q) + prfv_pkg::NSP_W'(byte_s1)
				+ prfv_pkg::NSP_W'(prfv_pkg::ID_BYTES + 1);
		end
		len      = prfv_pkg::NSP_W'(pos_q) + prfv_pkg::NSP_W'(1);
		at_limit = len >= prfv_pkg::NSP_W'(prfv_pkg::MAX_FRAME_BYTES);
		ok = type_ok_n && !too_long_q
			&& (len >= prfv_pkg::NSP_W'(prfv_pkg::MIN_FRAME_LEN))
			&& (len <= prfv_pkg::NSP_W'(prfv_pkg::MAX_FRAME_BYTES))
			&& (last2_n == 16'h0000)
			&& (nsp_n == len);
	end

	// Build the result: verdict on the last byte, otherwise a header at a size byte
	always_comb begin
		res       = '0;
		res_valid = last_s1 || hdr;
		if (last_s1) begin
			res.kind        = prfv_pkg::KIND_VERDICT;
			res.frame_valid = ok;
			res.item_count  = ok ? items_n : '0;
		end else begin
			res.kind        = prfv_pkg::KIND_HEADER;
			res.item_index  = items_q;
			res.param_id    = {last2_q[7:0], last2_q[15:8]};
			res.item_size   = byte_s1;
			res.data_offset = prfv_pkg::OFF_W'(len);
		end
	end

	// Advance the state; restart after the last byte, saturate past the limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			nsp_q      <= prfv_pkg::NSP_W'(prfv_pkg::FIRST_SIZE_POS);
			items_q    <= '0;
			last2_q    <= '0;
			type_lo_q  <= '0;
			type_ok_q  <= 1'b0;
			too_long_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				pos_q      <= '0;
				nsp_q      <= prfv_pkg::NSP_W'(prfv_pkg::FIRST_SIZE_POS);
				items_q    <= '0;
				last2_q    <= '0;
				type_lo_q  <= '0;
				type_ok_q  <= 1'b0;
				too_long_q <= 1'b0;
			end else begin
				nsp_q     <= nsp_n;
				items_q   <= items_n;
				last2_q   <= last2_n;
				type_lo_q <= type_lo_n;
				type_ok_q <= type_ok_n;
				if (at_limit) begin
					too_long_q <= 1'b1;
					pos_q      <= prfv_pkg::POS_W'(prfv_pkg::MAX_FRAME_BYTES);
				end else begin
					pos_q <= prfv_pkg::POS_W'(len);
				end
			end
		end
	end

endmodule

@@ hdl/prfv_output_reg.sv @@
module prfv_output_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              res_valid,
	input  prfv_pkg::result_t res,
	output logic              out_free,
	output logic              out_valid,
	input  logic              out_ready,
	output prfv_pkg::result_t out_res_q
);

	// The register can take a new result when empty or being drained
	assign out_free = !out_valid || out_ready;

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= res_valid;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Load the payload
	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_res_q <= res;
		end
	end

endmodule

@@ hdl/param_request_frame_validator_unit.sv @@
// Parameter-request frame validator.
// Input channel (in_valid/in_ready) takes one frame byte per item in data_byte,
// with last_byte set on the final byte. Each accepted item may produce one
// result on the output channel (out_valid/out_ready): an item header at every
// size byte (result_kind 0: item_index, param_id, item_size, data_offset) or,
// on the last byte, a verdict (result_kind 1: frame_valid, item_count).
// cfg_wr_en/cfg_wr_data write the expected frame type; write only while idle.
// An accepted byte is held in the input register and its result is then
// loaded into the result register; a full result register that the receiver
// has not taken holds the byte back. Throughput: one byte per cycle while the receiver keeps out_ready
// high; the rate is set by the single pass of frame state update between the
// input register and the result register.
// Reset clears the frame state, the expected frame type (to 0) and both
// registers' valid flags. When the receiver stalls, the result register holds
// its item, the input register holds at most one byte, and in_ready drops
// once both are full; bytes that produce no result still wait behind a full
// result register.
module param_request_frame_validator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [15:0]                  cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   data_byte,
	input  logic                         last_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         result_kind,
	output logic [prfv_pkg::IDX_W-1:0]   item_index,
	output logic [15:0]                  param_id,
	output logic [7:0]                   item_size,
	output logic [prfv_pkg::OFF_W-1:0]   data_offset,
	output logic                         frame_valid,
	output logic [prfv_pkg::IDX_W-1:0]   item_count
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              advance;
	logic              out_free;
	logic              res_valid;
	prfv_pkg::result_t res;
	prfv_pkg::result_t out_res_q;

	// Move the buffered byte on when the result register has room
	assign advance = valid_s1 && out_free;

	prfv_input_stage u_input (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.last_s1   (last_s1)
	);

	prfv_frame_tracker u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.advance     (advance),
		.byte_s1     (byte_s1),
		.last_s1     (last_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	prfv_output_reg u_output (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res_q (out_res_q)
	);

	// Unpack the result onto the ports
	assign result_kind = out_res_q.kind;
	assign item_index  = out_res_q.item_index;
	assign param_id    = out_res_q.param_id;
	assign item_size   = out_res_q.item_size;
	assign data_offset = out_res_q.data_offset;
	assign frame_valid = out_res_q.frame_valid;
	assign item_count  = out_res_q.item_count;

endmodule
